// ===== src/grid_path_count_with_obstacles_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_PATH_COUNT_WITH_OBSTACLES_CORE_MACROS_SVH
`define GRID_PATH_COUNT_WITH_OBSTACLES_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define GPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define GPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gpc_pkg.sv =====
`default_nettype none

package gpc_pkg;

  // Largest grid side held by the map and the row buffer.
  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = $clog2(MAX_SIZE);

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int COORD_W = 5;
  localparam int CNT_W   = 28;

  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [COORD_W-1:0] GRID_RESET = COORD_W'(16);

  // Operation codes of a request.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_BLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_WR,
    ST_ROW,
    ST_CELL,
    ST_OUT
  } gpc_state_t;

  // Access to the blocked map from the sequencer.
  typedef struct packed {
    logic             clr;
    logic             rd;
    logic             wr;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } gpc_map_req_t;

  // Finished count waiting for the output register.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic             invalid;
  } gpc_res_t;

  // Saturating add of two path counts.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/gpc_req_if.sv =====
`default_nettype none

interface gpc_req_if;
  import gpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;

  modport source (output valid, operation, cell_x, cell_y, input ready);
  modport sink (input valid, operation, cell_x, cell_y, output ready);
endinterface

`default_nettype wire

// ===== src/gpc_rsp_if.sv =====
`default_nettype none

interface gpc_rsp_if;
  import gpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] path_count;
  logic             start_invalid;

  modport source (output valid, path_count, start_invalid, input ready);
  modport sink (input valid, path_count, start_invalid, output ready);
endinterface

`default_nettype wire

// ===== src/grid_path_count_with_obstacles_core.sv =====
// Lattice path counter with blocked cells.
// Requests arrive on the request channel (valid/ready): operation 0 clears
// the blocked map, 1 marks cell (cell_x, cell_y) blocked, 2 asks for the
// number of right/down paths from that cell to corner (grid_size, grid_size).
// Only a count returns an item on the result channel (valid/ready).
// grid_size is to be written through cfg_wen/cfg_wdata only while the
// block is idle; the block itself does not enforce this. A clear is done
// when it is accepted; a block reads the map row, then writes it back in
// ST_MAP_WR. A count sweeps rows from the bottom up: each row fetches its
// map word in ST_ROW, then updates one cell a cycle in ST_CELL, from the
// right edge to the start column.
// A start outside the grid skips the sweep and goes straight to ST_OUT.
// The output register holds a finished result while new requests are
// taken; a second result waits in the sweep until the receiver takes the
// first, and no request is accepted meanwhile.
// Reset empties the blocked map at once, sets grid_size to 16 and drops
// any pending result.
`default_nettype none

module grid_path_count_with_obstacles_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [gpc_pkg::COORD_W-1:0] cfg_wdata,
  gpc_req_if.sink                          request,
  gpc_rsp_if.source                        result
);
  import gpc_pkg::*;

  logic [COORD_W-1:0] grid_size;
  logic [MAX_SIZE-1:0] row_bits;
  gpc_map_req_t       map_req;
  gpc_res_t           res;
  logic               res_take;

  // Grid size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
    end else if (cfg_wen) begin
      grid_size <= cfg_wdata;
    end
  end

  gpc_map u_map (
    .clk      (clk),
    .rst      (rst),
    .req      (map_req),
    .row_bits (row_bits)
  );

  gpc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .grid_size (grid_size),
    .map_req   (map_req),
    .row_bits  (row_bits),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: loads when empty or being emptied.
  assign res_take = res.valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result.path_count    <= res.count;
      result.start_invalid <= res.invalid;
    end
  end

endmodule

`default_nettype wire

// ===== src/gpc_ram.sv =====
`default_nettype none

module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/gpc_map.sv =====
`default_nettype none

module gpc_map (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gpc_pkg::gpc_map_req_t req,
  output logic [gpc_pkg::MAX_SIZE-1:0] row_bits
);
  import gpc_pkg::*;

  logic [MAX_SIZE-1:0] row_valid;
  logic                row_ok;
  logic [MAX_SIZE-1:0] ram_rd_data;
  logic [MAX_SIZE-1:0] wr_data;

  // A row never written since the last clear reads as all open.
  assign row_bits = row_ok ? ram_rd_data : '0;

  // A block merges one bit into the row read in the cycle before.
  assign wr_data = row_bits | (MAX_SIZE'(1) << req.col);

  gpc_ram #(
    .WIDTH (MAX_SIZE),
    .DEPTH (MAX_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr),
    .wr_addr (req.row),
    .wr_data (wr_data),
    .rd_en   (req.rd),
    .rd_addr (req.row),
    .rd_data (ram_rd_data)
  );

  // Row valid bits: a clear drops them all at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_ok    <= 1'b0;
    end else begin
      if (req.clr) begin
        row_valid <= '0;
      end else if (req.wr) begin
        row_valid[req.row] <= 1'b1;
      end
      if (req.rd) begin
        row_ok <= row_valid[req.row];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gpc_seq.sv =====
`default_nettype none

module gpc_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  gpc_req_if.sink                         request,
  input  wire logic [gpc_pkg::COORD_W-1:0] grid_size,
  output gpc_pkg::gpc_map_req_t           map_req,
  input  wire logic [gpc_pkg::MAX_SIZE-1:0] row_bits,
  output gpc_pkg::gpc_res_t               res,
  input  wire logic                       res_take
);
  import gpc_pkg::*;

  gpc_state_t state, state_next;

  logic [COORD_W-1:0] n;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W-1:0] y;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] p_x;
  logic [CNT_W-1:0]   right;
  logic [CNT_W-1:0]   res_count;
  logic               res_invalid;

  logic               accept;
  logic [COORD_W-1:0] n_in;
  logic               start_bad;
  logic               block_ok;

  logic [IDX_W-1:0]   p_idx;
  logic               last_col;
  logic               last_row;
  logic [CNT_W-1:0]   right_v;
  logic [CNT_W-1:0]   below_v;
  logic [CNT_W-1:0]   v;
  logic               issue;
  logic               row_done;

  logic               buf_rd_en;
  logic [IDX_W-1:0]   buf_rd_addr;
  logic               buf_wr_en;
  logic [CNT_W-1:0]   buf_rd_data;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;

  // Size in use: zero counts as one, anything above the map as the map.
  always_comb begin
    if (grid_size == '0) begin
      n_in = COORD_W'(1);
    end else if (int'(grid_size) > MAX_SIZE) begin
      n_in = COORD_W'(MAX_SIZE);
    end else begin
      n_in = grid_size;
    end
  end

  assign start_bad = (request.cell_x == '0) || (request.cell_x > n_in) ||
                     (request.cell_y == '0) || (request.cell_y > n_in);
  assign block_ok  = (request.cell_x != '0) && (int'(request.cell_x) <= MAX_SIZE) &&
                     (request.cell_y != '0) && (int'(request.cell_y) <= MAX_SIZE);

  // Cell update: zero if blocked, one at the corner, else right + below.
  assign p_idx    = IDX_W'(p_x - COORD_W'(1));
  assign last_col = (p_x == n);
  assign last_row = (y == n);
  assign right_v  = last_col ? '0 : right;
  assign below_v  = last_row ? '0 : buf_rd_data;

  always_comb begin
    if (row_bits[p_idx]) begin
      v = '0;
    end else if (last_col && last_row) begin
      v = CNT_W'(1);
    end else begin
      v = sat_add(right_v, below_v);
    end
  end

  assign issue    = (state == ST_CELL) && (x >= cx);
  assign row_done = (state == ST_CELL) && (p_x == cx);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (request.operation)
            OP_BLOCK: state_next = block_ok ? ST_MAP_WR : ST_IDLE;
            OP_COUNT: state_next = start_bad ? ST_OUT : ST_ROW;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_MAP_WR: state_next = ST_IDLE;
      ST_ROW:    state_next = ST_CELL;
      ST_CELL: begin
        if (row_done) begin
          state_next = (y == cy) ? ST_OUT : ST_ROW;
        end
      end
      ST_OUT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and the result.
  always_comb begin
    map_req     = '0;
    buf_rd_en   = 1'b0;
    buf_rd_addr = p_idx;
    buf_wr_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        map_req.clr = accept && (request.operation == OP_CLEAR);
        map_req.rd  = accept && (request.operation == OP_BLOCK) && block_ok;
        map_req.row = IDX_W'(request.cell_y - COORD_W'(1));
        map_req.col = IDX_W'(request.cell_x - COORD_W'(1));
      end
      ST_MAP_WR: begin
        map_req.wr  = 1'b1;
        map_req.row = IDX_W'(cy - COORD_W'(1));
        map_req.col = IDX_W'(cx - COORD_W'(1));
      end
      ST_ROW: begin
        map_req.rd  = 1'b1;
        map_req.row = IDX_W'(y - COORD_W'(1));
        buf_rd_en   = 1'b1;
        buf_rd_addr = IDX_W'(n - COORD_W'(1));
      end
      ST_CELL: begin
        buf_wr_en   = 1'b1;
        buf_rd_en   = issue;
        buf_rd_addr = IDX_W'(x - COORD_W'(1));
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign res.valid   = (state == ST_OUT);
  assign res.count   = res_count;
  assign res.invalid = res_invalid;

  gpc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_SIZE)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (p_idx),
    .wr_data (v),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counters and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      n           <= n_in;
      cx          <= request.cell_x;
      cy          <= request.cell_y;
      y           <= n_in;
      res_count   <= '0;
      res_invalid <= start_bad;
    end
    if (state == ST_ROW) begin
      p_x <= n;
      x   <= n - COORD_W'(1);
    end
    if (issue) begin
      p_x <= x;
      x   <= x - COORD_W'(1);
    end
    if (state == ST_CELL) begin
      right <= v;
    end
    if (row_done) begin
      if (y == cy) begin
        res_count <= v;
      end else begin
        y <= y - COORD_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gpc_checker.sv =====
`default_nettype none
`include "grid_path_count_with_obstacles_core_macros.svh"

module gpc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic [gpc_pkg::OP_W-1:0]    req_operation,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [gpc_pkg::CNT_W-1:0]   rsp_path_count,
  input wire logic                        rsp_start_invalid
);
  import gpc_pkg::*;

  logic req_take;

  // A request is taken when both sides of the handshake are high.
  assign req_take = req_valid && req_ready;

  // A result is held until the receiver takes it.
  `GPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

  // An out-of-grid start always reports no paths.
  `GPC_ASSERT_NOW(a_invalid_zero, rsp_valid && rsp_start_invalid, rsp_path_count == '0, "bad count")

  // A count request leaves the request channel busy in the cycle after it is taken.
  `GPC_ASSERT_NEXT(a_count_busy, req_take && req_operation == OP_COUNT, !req_ready, "count not held")

  // A clear finishes within the cycle it is accepted.
  `GPC_ASSERT_NEXT(a_clear_quick, req_take && req_operation == OP_CLEAR, req_ready, "clear stalled")

endmodule

bind grid_path_count_with_obstacles_core gpc_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (request.valid),
  .req_ready         (request.ready),
  .req_operation     (request.operation),
  .rsp_valid         (result.valid),
  .rsp_ready         (result.ready),
  .rsp_path_count    (result.path_count),
  .rsp_start_invalid (result.start_invalid)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import gpc_pkg::*;

  // Operation code that the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 19;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_PHASES    = 10;

  // One expected item on the result channel.
  typedef struct packed {
    logic [CNT_W-1:0] path_count;
    logic             start_invalid;
  } path_result_t;

  // Keeps its own copy of the blocked map and grid size, predicts each
  // count, and checks results in order.
  class path_count_checker;
    logic [COORD_W-1:0] grid_size;
    bit                 blocked [MAX_SIZE][MAX_SIZE];
    path_result_t       expected_counts [$];
    int                 errors;
    int                 checked;
    int                 op_seen [4];

    function new();
      grid_size = GRID_RESET;
      foreach (blocked[r, c]) blocked[r][c] = 1'b0;
      errors  = 0;
      checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void write_size(input logic [COORD_W-1:0] value);
      grid_size = value;
    endfunction

    // Sizes of zero and above the map are folded into range.
    function int size_in_use();
      int n;
      n = grid_size;
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    // Sweep from the corner row upward, each row right to left, through a
    // single row of partial sums.
    function path_result_t predict_count(input int x, input int y);
      path_result_t     res;
      logic [CNT_W-1:0] row_sum [MAX_SIZE];
      logic [CNT_W-1:0] right;
      logic [CNT_W-1:0] below;
      logic [CNT_W:0]   total;
      int               n;
      n = size_in_use();
      res.path_count    = '0;
      res.start_invalid = 1'b0;
      if (x < 1 || x > n || y < 1 || y > n) begin
        res.start_invalid = 1'b1;
        return res;
      end
      for (int r = n; r >= y; r--) begin
        for (int c = n; c >= x; c--) begin
          if (blocked[r-1][c-1]) begin
            row_sum[c-1] = '0;
          end else if (r == n && c == n) begin
            row_sum[c-1] = CNT_W'(1);
          end else begin
            right = (c < n) ? row_sum[c] : '0;
            below = (r < n) ? row_sum[c-1] : '0;
            total = {1'b0, right} + {1'b0, below};
            row_sum[c-1] = total[CNT_W] ? CNT_MAX : total[CNT_W-1:0];
          end
        end
      end
      res.path_count = row_sum[x-1];
      return res;
    endfunction

    // Apply an accepted request to the map, or queue the count it asks for.
    function void note_request(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
      op_seen[op]++;
      case (op)
        OP_CLEAR: begin
          foreach (blocked[r, c]) blocked[r][c] = 1'b0;
        end
        OP_BLOCK: begin
          if (x >= 1 && x <= MAX_SIZE && y >= 1 && y <= MAX_SIZE) blocked[y-1][x-1] = 1'b1;
        end
        OP_COUNT: begin
          expected_counts.insert(expected_counts.size(), predict_count(x, y));
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic [CNT_W-1:0] count, input logic invalid);
      path_result_t want;
      checked++;
      if (expected_counts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got count %0d invalid %0b",
                 $time, count, invalid);
        return;
      end
      want = expected_counts.pop_front();
      if (count !== want.path_count) begin
        errors++;
        $display("%0t: path_count mismatch, expected %0d, got %0d",
                 $time, want.path_count, count);
      end
      if (invalid !== want.start_invalid) begin
        errors++;
        $display("%0t: start_invalid mismatch, expected %0b, got %0b",
                 $time, want.start_invalid, invalid);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic [COORD_W-1:0] cfg_wdata;
  logic               tx_calm;
  logic               rx_calm;
  logic               hold_pending;
  int                 sizes_used;

  gpc_req_if req_ch ();
  gpc_rsp_if rsp_ch ();

  path_count_checker sb = new();

  grid_path_count_with_obstacles_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .request   (req_ch),
    .result    (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch the configuration port and both channels at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wen) sb.write_size(cfg_wdata);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.operation, req_ch.cell_x, req_ch.cell_y);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.path_count, rsp_ch.start_invalid);
    end
  end

  // Result receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_calm) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one request, with a random gap first, and wait for its handshake.
  // The valid stays high on return so back-to-back requests need no toggle.
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
    if (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.cell_x    <= x;
    req_ch.cell_y    <= y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop offering, let every expected result arrive, then let the last
  // clear or block finish inside the block.
  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_size(input logic [COORD_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sizes_used++;
  endtask

  // Mostly in-grid blocks and counts; some clears, unused ops, stray cells.
  task automatic random_phase(input int num_items);
    int                 done;
    int                 pick;
    int                 n;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    done = 0;
    while (done < num_items) begin
      n    = sb.size_in_use();
      pick = $urandom_range(99);
      if (pick < 4) op = OP_CLEAR;
      else if (pick < 40) op = OP_BLOCK;
      else if (pick < 97) op = OP_COUNT;
      else op = OP_UNUSED;
      pick = $urandom_range(9);
      if (pick == 0) begin
        x = COORD_W'($urandom_range(31));
        y = COORD_W'($urandom_range(31));
      end else if (pick == 1 && op == OP_BLOCK) begin
        x = COORD_W'($urandom_range(MAX_SIZE, 1));
        y = COORD_W'($urandom_range(MAX_SIZE, 1));
      end else begin
        x = COORD_W'($urandom_range(n, 1));
        y = COORD_W'($urandom_range(n, 1));
      end
      offer_request(op, x, y);
      if (op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    logic [COORD_W-1:0] phase_size [NUM_PHASES];
    phase_size = '{16, 1, 0, 31, 2, 17, 5, 16, 9, 0};
    phase_size[NUM_PHASES-1] = COORD_W'($urandom_range(31));

    rst              <= 1'b1;
    cfg_wen          <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_CLEAR;
    req_ch.cell_x    <= '0;
    req_ch.cell_y    <= '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_pending = 1'b0;
    sizes_used   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests on the full reset grid: the largest count, the
    // corner itself, starts off the grid, blocks off the map, a blocked
    // start, the unused operation, a blocked corner, and a clear.
    offer_request(OP_COUNT, 1, 1);
    offer_request(OP_COUNT, 16, 16);
    offer_request(OP_COUNT, 16, 1);
    offer_request(OP_COUNT, 0, 5);
    offer_request(OP_COUNT, 5, 0);
    offer_request(OP_COUNT, 17, 1);
    offer_request(OP_COUNT, 31, 31);
    offer_request(OP_BLOCK, 0, 3);
    offer_request(OP_BLOCK, 17, 2);
    offer_request(OP_BLOCK, 31, 31);
    offer_request(OP_COUNT, 1, 1);
    offer_request(OP_BLOCK, 8, 8);
    offer_request(OP_COUNT, 8, 8);
    offer_request(OP_COUNT, 1, 1);
    offer_request(OP_UNUSED, 31, 31);
    offer_request(OP_UNUSED, 0, 0);
    offer_request(OP_BLOCK, 16, 16);
    offer_request(OP_COUNT, 1, 1);
    offer_request(OP_CLEAR, 0, 0);
    offer_request(OP_COUNT, 1, 1);

    // A block outside the grid in use is still kept in the map.
    drain_and_settle();
    write_grid_size(4);
    offer_request(OP_BLOCK, 10, 10);
    offer_request(OP_COUNT, 1, 1);
    drain_and_settle();
    write_grid_size(16);
    offer_request(OP_COUNT, 10, 10);
    offer_request(OP_CLEAR, 31, 31);

    // Random phases over several grid sizes, the extremes among them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      write_grid_size(phase_size[p]);
      tx_calm = (p == 7);
      rx_calm = (p == 7);
      if (p == 0) hold_pending = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain_and_settle();
    $display("Run covered %0d clears, %0d blocks, %0d counts and %0d unused requests",
             sb.op_seen[OP_CLEAR], sb.op_seen[OP_BLOCK], sb.op_seen[OP_COUNT],
             sb.op_seen[OP_UNUSED]);
    $display("over %0d grid size settings; %0d results checked, %0d mismatches.",
             sizes_used, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
